FILE: sv/tksc_pkg.sv
// ----------------------------------------------------------------------------
// tksc_pkg
// Shared types, codes and the CRC-16 byte update for the tag key search.
// ----------------------------------------------------------------------------
package tksc_pkg;

  // CRC-16/XMODEM generator polynomial
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_MATCH   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CRC,
    S_CHECK,
    S_DONE
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic    capture;    // register the accepted item
    logic    mem_wr;     // append entry to the store
    logic    cnt_inc;    // bump the entry count
    logic    idx_clr;    // restart the entry walk
    logic    idx_inc;    // move to the next entry
    logic    rd_en;      // read the current entry
    logic    step_clr;   // restart the byte sequence
    logic    crc_step;   // run one byte through both CRCs
    logic    out_load;   // load the output register
    status_t res_status; // status to publish
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_query;
    logic full;
    logic empty;
    logic last_step;
    logic hit;
    logic last_entry;
    logic hit_new;
  } sts_t;

  // one byte through CRC-16/XMODEM, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/tksc_if.sv
// ----------------------------------------------------------------------------
// tksc_if
// Valid/ready channels for the tag key search: query/load items in, results out.
// ----------------------------------------------------------------------------
interface tksc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] entry_ident;
  logic [15:0] entry_old_key;
  logic [15:0] entry_new_key;
  logic [7:0]  nonce_one;
  logic [7:0]  nonce_two;
  logic [15:0] tag_reply;

  modport source (
    output valid, kind, entry_ident, entry_old_key, entry_new_key,
           nonce_one, nonce_two, tag_reply,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_ident, entry_old_key, entry_new_key,
           nonce_one, nonce_two, tag_reply,
    output ready
  );
endinterface

interface tksc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] match_index;
  logic        matched_old_key;

  modport source (
    output valid, status, match_index, matched_old_key,
    input  ready
  );
  modport sink (
    input  valid, status, match_index, matched_old_key,
    output ready
  );
endinterface

FILE: sv/tag_key_search_crc16.sv
// ----------------------------------------------------------------------------
// tag_key_search_crc16
// Tag store with keyed CRC-16/XMODEM search over old and new keys.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready items. kind 0 appends {ident, old key, new key} to the
//            store when not full; kind 1 searches the store with nonce_one,
//            nonce_two and tag_reply.
//   out_ch : one result item per input item, in order: loaded, store full,
//            match (index and old-key flag) or no match.
// Path (acceptance to out_ch.valid):
//   load, or query on an empty store : decode, then done, then output register.
//   query : walks the entries until a hit or the last entry; each entry takes
//     a read, one-byte CRC steps over IDENT_BITS + 3 message bytes for both
//     keys side by side, and a compare.
// Flow: one item in work at a time; in_ch.ready is high only when idle, from
//   the cycle after the result is loaded.
// Reset: the entry count clears; store contents are kept but not read again
//   until rewritten. The output register empties.
// Stall: a finished result sits in the output register while the next item
//   is accepted and worked on; that item's result waits until the register
//   is taken.
// ----------------------------------------------------------------------------
module tag_key_search_crc16 #(
  parameter int STORE_DEPTH = 4096,
  parameter int IDENT_BITS  = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  tksc_in_if.sink    in_ch,
  tksc_out_if.source out_ch
);
  import tksc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  tksc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store and CRC engines
  tksc_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .IDENT_BITS  (IDENT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_ch.kind),
    .in_entry_ident      (in_ch.entry_ident),
    .in_entry_old_key    (in_ch.entry_old_key),
    .in_entry_new_key    (in_ch.entry_new_key),
    .in_nonce_one        (in_ch.nonce_one),
    .in_nonce_two        (in_ch.nonce_two),
    .in_tag_reply        (in_ch.tag_reply),
    .out_status          (out_ch.status),
    .out_match_index     (out_ch.match_index),
    .out_matched_old_key (out_ch.matched_old_key)
  );

endmodule

FILE: sv/tksc_ctrl.sv
// ----------------------------------------------------------------------------
// tksc_ctrl
// Controller: sequences loads, the entry walk and the byte-serial CRC steps.
// ----------------------------------------------------------------------------
module tksc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tksc_pkg::sts_t  sts,
  output tksc_pkg::cmd_t  cmd
);
  import tksc_pkg::*;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= ST_LOADED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.res_status = res_r;
    in_ready       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_query) begin
          if (sts.empty) begin
            res_nxt   = ST_NOMATCH;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end else if (sts.full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.mem_wr  = 1'b1;
          cmd.cnt_inc = 1'b1;
          res_nxt     = ST_LOADED;
          state_nxt   = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_en    = 1'b1;
        cmd.step_clr = 1'b1;
        state_nxt    = S_CRC;
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.last_step) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.hit) begin
          res_nxt   = ST_MATCH;
          state_nxt = S_DONE;
        end else if (sts.last_entry) begin
          res_nxt   = ST_NOMATCH;
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // checks
  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> !sts.full)
    else $error("store write while full");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_no_walk_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idx_inc |-> !sts.last_entry)
    else $error("entry walk past the last entry");

  a_hit_reports_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && sts.hit) |=> (state_r == S_DONE && res_r == ST_MATCH))
    else $error("hit not reported as match");

endmodule

FILE: sv/tksc_dp.sv
// ----------------------------------------------------------------------------
// tksc_dp
// Datapath: entry store, entry count, twin CRC-16 engines and result register.
// ----------------------------------------------------------------------------
module tksc_dp #(
  parameter int STORE_DEPTH = 4096,
  parameter int IDENT_BITS  = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tksc_pkg::cmd_t  cmd,
  output tksc_pkg::sts_t  sts,
  input  logic            in_kind,
  input  logic [11:0]     in_entry_ident,
  input  logic [15:0]     in_entry_old_key,
  input  logic [15:0]     in_entry_new_key,
  input  logic [7:0]      in_nonce_one,
  input  logic [7:0]      in_nonce_two,
  input  logic [15:0]     in_tag_reply,
  output logic [1:0]      out_status,
  output logic [11:0]     out_match_index,
  output logic            out_matched_old_key
);
  import tksc_pkg::*;

  localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int STEP_W = $clog2(IDENT_BITS + 4);
  localparam int ENT_W  = IDENT_BITS + 32;

  // entry store: {ident, old key, new key}
  logic [ENT_W-1:0] mem [STORE_DEPTH];
  logic [ENT_W-1:0] rd_q_r;
  logic [ENT_W-1:0] ent_r;

  logic                  kind_r;
  logic [7:0]            n1_r, n2_r;
  logic [15:0]           m2_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      idx_r;
  logic [STEP_W-1:0]     step_r;
  logic [15:0]           crc_new_r, crc_old_r;
  logic [IDENT_BITS-1:0] ident_sh_r;

  logic [15:0]             rd_old_key, rd_new_key;
  logic [IDENT_BITS-1:0]   rd_ident;
  logic [IDENT_BITS+11:0]  ident_ext;
  logic [CNT_W+11:0]       idx_ext;
  logic [7:0]              b_new, b_old;
  logic [15:0]             crc_in_new, crc_in_old;
  logic                    hit_new, hit_old;

  assign rd_new_key = rd_q_r[15:0];
  assign rd_old_key = rd_q_r[31:16];
  assign rd_ident   = rd_q_r[ENT_W-1:32];
  assign ident_ext  = {{IDENT_BITS{1'b0}}, in_entry_ident};
  assign idx_ext    = {12'b0, idx_r};

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      ent_r  <= {ident_ext[IDENT_BITS-1:0], in_entry_old_key, in_entry_new_key};
      n1_r   <= in_nonce_one;
      n2_r   <= in_nonce_two;
      m2_r   <= in_tag_reply;
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[count_r[IDX_W-1:0]] <= ent_r;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // walk index and byte step counter
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.step_clr) begin
      step_r <= '0;
    end else if (cmd.crc_step) begin
      step_r <= step_r + STEP_W'(1);
    end
  end

  // message byte: key low byte, identifier bits MSB first, then both nonces
  always_comb begin
    if (step_r == '0) begin
      b_new = rd_new_key[7:0];
      b_old = rd_old_key[7:0];
    end else if (step_r <= STEP_W'(IDENT_BITS)) begin
      b_new = {7'b0, ident_sh_r[IDENT_BITS-1]};
      b_old = {7'b0, ident_sh_r[IDENT_BITS-1]};
    end else if (step_r == STEP_W'(IDENT_BITS + 1)) begin
      b_new = n1_r;
      b_old = n1_r;
    end else begin
      b_new = n2_r;
      b_old = n2_r;
    end
  end

  assign crc_in_new = (step_r == '0) ? 16'h0000 : crc_new_r;
  assign crc_in_old = (step_r == '0) ? 16'h0000 : crc_old_r;

  // CRC engines, one byte per cycle each
  always_ff @(posedge clk) begin
    if (cmd.crc_step) begin
      crc_new_r <= crc_byte(crc_in_new, b_new);
      crc_old_r <= crc_byte(crc_in_old, b_old);
      if (step_r == '0) begin
        ident_sh_r <= rd_ident;
      end else begin
        ident_sh_r <= ident_sh_r << 1;
      end
    end
  end

  // keyed compare
  assign hit_new = (crc_new_r ^ rd_new_key) == m2_r;
  assign hit_old = (crc_old_r ^ rd_old_key) == m2_r;

  // status to controller
  always_comb begin
    sts.is_query   = (kind_r == KIND_QUERY);
    sts.full       = (count_r == CNT_W'(STORE_DEPTH));
    sts.empty      = (count_r == '0);
    sts.last_step  = (step_r == STEP_W'(IDENT_BITS + 2));
    sts.hit        = hit_new || hit_old;
    sts.last_entry = ((idx_r + CNT_W'(1)) == count_r);
    sts.hit_new    = hit_new;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.res_status;
      if (cmd.res_status == ST_MATCH) begin
        out_match_index     <= idx_ext[11:0];
        out_matched_old_key <= !hit_new;
      end else begin
        out_match_index     <= '0;
        out_matched_old_key <= 1'b0;
      end
    end
  end

endmodule
